### rtl/hrdp_pkg.sv
// hrdp_pkg: shared types and constants for the hid report descriptor parser
// no dependencies; imported by hrdp_front, hrdp_back and the top level
`timescale 1ns / 1ps
`default_nettype none

package hrdp_pkg;

	localparam int MAX_FIELDS = 64;
	localparam int FCNT_W     = $clog2(MAX_FIELDS + 1);

	localparam logic [7:0] LONG_PREFIX = 8'hFE;

	localparam logic [1:0] SIZE_FOUR = 2'd3;

	localparam logic [1:0] ITYPE_MAIN   = 2'd0;
	localparam logic [1:0] ITYPE_GLOBAL = 2'd1;
	localparam logic [1:0] ITYPE_LOCAL  = 2'd2;

	localparam logic [3:0] TAG_INPUT   = 4'd8;
	localparam logic [3:0] TAG_OUTPUT  = 4'd9;
	localparam logic [3:0] TAG_FEATURE = 4'd11;

	localparam logic [3:0] TAG_USAGE_PAGE   = 4'd0;
	localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
	localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
	localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;

	localparam logic [3:0] TAG_USAGE = 4'd0;

	localparam logic [1:0] KIND_INPUT   = 2'd0;
	localparam logic [1:0] KIND_OUTPUT  = 2'd1;
	localparam logic [1:0] KIND_FEATURE = 2'd2;

	typedef enum logic [1:0] {
		PH_PREFIX   = 2'd0,
		PH_DATA     = 2'd1,
		PH_LONGLEN  = 2'd2,
		PH_LONGSKIP = 2'd3
	} phase_t;

	typedef struct packed {
		logic        item_ok;
		logic        last;
		logic [1:0]  itype;
		logic [3:0]  tag;
		logic [31:0] data;
	} item_t;

	typedef struct packed {
		logic [5:0]  field_index;
		logic [1:0]  report_kind;
		logic [7:0]  report_number;
		logic [7:0]  page_of_usage;
		logic [15:0] usage_code;
		logic [7:0]  bits_per_entry;
		logic [7:0]  entry_count;
		logic [31:0] main_flags;
	} record_t;

endpackage

`default_nettype wire

### rtl/hrdp_front.sv
// hrdp_front: byte tokenizer that assembles short items and skips long items
// depends on hrdp_pkg; feeds completed items and end marks into a two-entry queue
`timescale 1ns / 1ps
`default_nettype none

module hrdp_front
	import hrdp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] desc_byte,
	input  wire logic       last_byte,
	input  wire logic       push,
	output logic            full,
	output logic            item_valid,
	output item_t           item_head,
	input  wire logic       item_pop
);

	phase_t      phase_q, phase_d;
	logic [8:0]  left_q, left_d;
	logic [31:0] acc_q, acc_d;
	logic [1:0]  pos_q, pos_d;
	logic [1:0]  itype_q, itype_d;
	logic [3:0]  tag_q, tag_d;

	logic        accept;
	logic        done;
	item_t       item_new;

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        q_push;
	logic        q_pop;

	assign accept = push && !full;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		acc_d   = acc_q;
		pos_d   = pos_q;
		itype_d = itype_q;
		tag_d   = tag_q;
		done    = 1'b0;
		case (phase_q)
			PH_PREFIX: begin
				if (desc_byte == LONG_PREFIX) begin
					phase_d = PH_LONGLEN;
				end else begin
					itype_d = desc_byte[3:2];
					tag_d   = desc_byte[7:4];
					acc_d   = '0;
					pos_d   = '0;
					if (desc_byte[1:0] == 2'd0) begin
						done = 1'b1;
					end else begin
						left_d  = (desc_byte[1:0] == SIZE_FOUR) ? 9'd4 : {7'd0, desc_byte[1:0]};
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				acc_d[{pos_q, 3'b000} +: 8] = acc_q[{pos_q, 3'b000} +: 8] | desc_byte;
				pos_d = pos_q + 2'd1;
				if (left_q != 9'd0) begin
					left_d = left_q - 9'd1;
				end
				if (left_d == 9'd0) begin
					phase_d = PH_PREFIX;
					done    = 1'b1;
				end
			end
			PH_LONGLEN: begin
				left_d  = {1'b0, desc_byte} + 9'd1;
				phase_d = PH_LONGSKIP;
			end
			default: begin
				if (left_q != 9'd0) begin
					left_d = left_q - 9'd1;
				end
				if (left_d == 9'd0) begin
					phase_d = PH_PREFIX;
				end
			end
		endcase
	end

	always_comb begin
		item_new.item_ok = done;
		item_new.last    = last_byte;
		item_new.itype   = itype_d;
		item_new.tag     = tag_d;
		item_new.data    = acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			left_q  <= '0;
			acc_q   <= '0;
			pos_q   <= '0;
			itype_q <= '0;
			tag_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q <= PH_PREFIX;
				left_q  <= '0;
				acc_q   <= '0;
				pos_q   <= '0;
				itype_q <= '0;
				tag_q   <= '0;
			end else begin
				phase_q <= phase_d;
				left_q  <= left_d;
				acc_q   <= acc_d;
				pos_q   <= pos_d;
				itype_q <= itype_d;
				tag_q   <= tag_d;
			end
		end
	end

	// item queue toward the back part
	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item_head  = mem_q[rd_ptr_q];
	assign q_push     = accept && (done || last_byte);
	assign q_pop      = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= item_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (q_push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !q_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/hrdp_back.sv
// hrdp_back: applies items to the global and local settings and builds field records
// depends on hrdp_pkg; takes items from hrdp_front, holds records in a two-entry queue
`timescale 1ns / 1ps
`default_nettype none

module hrdp_back
	import hrdp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	input  item_t     item_head,
	output logic      item_pop,
	output logic      empty,
	input  wire logic pop,
	output record_t   rec_head
);

	logic [7:0]        page_q;
	logic [7:0]        size_q;
	logic [7:0]        rid_q;
	logic [7:0]        count_q;
	logic [15:0]       usage_q;
	logic [FCNT_W-1:0] nfields_q;

	logic              is_field;
	logic              emit;
	logic [1:0]        kind;
	record_t           rec_new;

	record_t           mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              q_pop;

	assign item_pop = item_valid && (cnt_q != 2'd2);

	always_comb begin
		is_field = item_head.item_ok && (item_head.itype == ITYPE_MAIN) &&
			(item_head.tag == TAG_INPUT || item_head.tag == TAG_OUTPUT ||
			 item_head.tag == TAG_FEATURE);
		emit = item_pop && is_field && (nfields_q < FCNT_W'(MAX_FIELDS));
		case (item_head.tag)
			TAG_INPUT:  kind = KIND_INPUT;
			TAG_OUTPUT: kind = KIND_OUTPUT;
			default:    kind = KIND_FEATURE;
		endcase
		rec_new.field_index    = nfields_q[5:0];
		rec_new.report_kind    = kind;
		rec_new.report_number  = rid_q;
		rec_new.page_of_usage  = page_q;
		rec_new.usage_code     = usage_q;
		rec_new.bits_per_entry = size_q;
		rec_new.entry_count    = count_q;
		rec_new.main_flags     = item_head.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q    <= '0;
			size_q    <= '0;
			rid_q     <= '0;
			count_q   <= '0;
			usage_q   <= '0;
			nfields_q <= '0;
		end else if (item_pop) begin
			if (item_head.last) begin
				page_q    <= '0;
				size_q    <= '0;
				rid_q     <= '0;
				count_q   <= '0;
				usage_q   <= '0;
				nfields_q <= '0;
			end else if (item_head.item_ok) begin
				if (emit) begin
					nfields_q <= nfields_q + FCNT_W'(1);
				end
				if (item_head.itype == ITYPE_GLOBAL) begin
					case (item_head.tag)
						TAG_USAGE_PAGE:   page_q  <= item_head.data[7:0];
						TAG_REPORT_SIZE:  size_q  <= item_head.data[7:0];
						TAG_REPORT_ID:    rid_q   <= item_head.data[7:0];
						TAG_REPORT_COUNT: count_q <= item_head.data[7:0];
						default: begin
						end
					endcase
				end
				if (item_head.itype == ITYPE_LOCAL && item_head.tag == TAG_USAGE) begin
					usage_q <= item_head.data[15:0];
				end
			end
		end
	end

	// record queue
	assign empty    = (cnt_q == 2'd0);
	assign rec_head = mem_q[rd_ptr_q];
	assign q_pop    = pop && !empty;

	always_ff @(posedge clk) begin
		if (emit) begin
			mem_q[wr_ptr_q] <= rec_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (emit) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (emit && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !emit) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/hid_report_descriptor_parser.sv
// a field record goes through the item queue and then the record queue before empty falls
// throughput: one descriptor byte per cycle, sustained while pop keeps pace with records
// full rises only when the two-entry item queue between tokenizer and back end fills
// reset: arst_n clears parse state, settings, field count and both queues at once
// hid_report_descriptor_parser: top level; depends on hrdp_pkg, hrdp_front, hrdp_back
`timescale 1ns / 1ps
`default_nettype none

module hid_report_descriptor_parser
	import hrdp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  desc_byte,
	input  wire logic        last_byte,
	input  wire logic        push,
	output logic             full,
	output logic             empty,
	input  wire logic        pop,
	output logic [5:0]       field_index,
	output logic [1:0]       report_kind,
	output logic [7:0]       report_number,
	output logic [7:0]       page_of_usage,
	output logic [15:0]      usage_code,
	output logic [7:0]       bits_per_entry,
	output logic [7:0]       entry_count,
	output logic [31:0]      main_flags
);

	logic    item_valid;
	logic    item_pop;
	item_t   item_head;
	record_t rec_head;

	hrdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_byte  (desc_byte),
		.last_byte  (last_byte),
		.push       (push),
		.full       (full),
		.item_valid (item_valid),
		.item_head  (item_head),
		.item_pop   (item_pop)
	);

	hrdp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_head  (item_head),
		.item_pop   (item_pop),
		.empty      (empty),
		.pop        (pop),
		.rec_head   (rec_head)
	);

	assign field_index    = rec_head.field_index;
	assign report_kind    = rec_head.report_kind;
	assign report_number  = rec_head.report_number;
	assign page_of_usage  = rec_head.page_of_usage;
	assign usage_code     = rec_head.usage_code;
	assign bits_per_entry = rec_head.bits_per_entry;
	assign entry_count    = rec_head.entry_count;
	assign main_flags     = rec_head.main_flags;

endmodule

`default_nettype wire

### rtl/hrdp_checker.sv
// hrdp_checker: port-level assertions for hid_report_descriptor_parser
// depends on the top level's ports only; attached by the bind at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module hrdp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic [7:0]  desc_byte,
	input wire logic        last_byte,
	input wire logic        push,
	input wire logic        full,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [5:0]  field_index,
	input wire logic [1:0]  report_kind,
	input wire logic [7:0]  report_number,
	input wire logic [7:0]  page_of_usage,
	input wire logic [15:0] usage_code,
	input wire logic [7:0]  bits_per_entry,
	input wire logic [7:0]  entry_count,
	input wire logic [31:0] main_flags
);

	// a waiting transaction holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(field_index) && $stable(main_flags) &&
			$stable(report_kind) && $stable(usage_code)))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (report_kind != 2'd3))
		else $error("invalid report kind");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");

	// the input side never stays full while nothing else is pending downstream
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && empty && !$past(full)) |=> !full || !empty)
		else $error("input side stuck full");

endmodule

bind hid_report_descriptor_parser hrdp_checker u_hrdp_checker (.*);

`default_nettype wire
